[rtl/core/edp_pkg.sv]
// Shared types and constants for the edit distance engine.
`default_nettype none

package edp_pkg;

   localparam int MAX_LEN_DEF = 1024;
   localparam int BYTE_W      = 8;
   localparam int LEN_OUT_W   = 11;

   localparam logic [BYTE_W-1:0] SPACE_CODE   = 8'h20;
   localparam logic [BYTE_W-1:0] NEWLINE_CODE = 8'h0A;

   typedef enum logic [1:0] {
      FUNC_REF    = 2'd0,
      FUNC_CAND   = 2'd1,
      FUNC_FINISH = 2'd2
   } func_type;

   // One accepted input word as seen by the core.
   typedef struct packed {
      logic              accept;
      func_type          func;
      logic [BYTE_W-1:0] data;
   } req_cmd_type;

   // One finished result.
   typedef struct packed {
      logic [LEN_OUT_W-1:0] distance;
      logic [LEN_OUT_W-1:0] ref_length;
      logic [LEN_OUT_W-1:0] cand_length;
      logic                 too_long;
   } result_type;

endpackage

`default_nettype wire

[rtl/core/edp_cell.sv]
// Single dynamic-programming cell: minimum of insert, delete and substitute costs.
`default_nettype none

module edp_cell #(
   parameter int W = 11
) (
   input  wire logic [W-1:0]              up,
   input  wire logic [W-1:0]              left,
   input  wire logic [W-1:0]              diag,
   input  wire logic [edp_pkg::BYTE_W-1:0] ref_char,
   input  wire logic [edp_pkg::BYTE_W-1:0] cand_char,
   output logic      [W-1:0]              cost_out
);
   import edp_pkg::*;

   logic [W:0] up_c;
   logic [W:0] left_c;
   logic [W:0] diag_c;
   logic [W:0] min_a;
   logic [W:0] min_b;

   always_comb begin
      up_c   = {1'b0, up} + (W+1)'(1);
      left_c = {1'b0, left} + (W+1)'(1);
      diag_c = {1'b0, diag} + ((ref_char == cand_char) ? (W+1)'(0) : (W+1)'(1));
      min_a  = (up_c < left_c) ? up_c : left_c;
      min_b  = (min_a < diag_c) ? min_a : diag_c;
   end

   // The minimum never exceeds the longest length, so it fits in W bits.
   assign cost_out = min_b[W-1:0];

endmodule

`default_nettype wire

[rtl/core/edp_core.sv]
// String buffers, row memory and the sequencer that walks the distance table.
`default_nettype none

module edp_core #(
   parameter int MAX_LEN = edp_pkg::MAX_LEN_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire edp_pkg::req_cmd_type cmd,
   input  wire logic                 out_free,
   output logic                      idle,
   output logic                      res_valid,
   output edp_pkg::result_type       result
);
   import edp_pkg::*;

   localparam int LEN_W  = $clog2(MAX_LEN + 1);
   localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROW,
      ST_READ,
      ST_CELL,
      ST_RESULT
   } state_type;

   state_type        state_ff,     state_in;
   logic [LEN_W-1:0] ref_count_ff,  ref_count_in;
   logic [LEN_W-1:0] cand_count_ff, cand_count_in;
   logic             ref_over_ff,   ref_over_in;
   logic             cand_over_ff,  cand_over_in;
   logic [LEN_W-1:0] row_ff,  row_in;
   logic [LEN_W-1:0] col_ff,  col_in;
   logic [LEN_W-1:0] left_ff, left_in;
   logic [LEN_W-1:0] diag_ff, diag_in;
   logic [LEN_W-1:0] dist_ff, dist_in;

   logic [BYTE_W-1:0] ref_mem_ff  [MAX_LEN];
   logic [BYTE_W-1:0] cand_mem_ff [MAX_LEN];
   logic [LEN_W-1:0]  dp_mem_ff   [MAX_LEN];
   logic [BYTE_W-1:0] ref_rd_ff;
   logic [BYTE_W-1:0] cand_rd_ff;
   logic [LEN_W-1:0]  dp_rd_ff;

   logic              kept;
   logic              ref_wr;
   logic              cand_wr;
   logic [ADDR_W-1:0] ref_wr_addr;
   logic [ADDR_W-1:0] cand_wr_addr;
   logic [ADDR_W-1:0] row_addr;
   logic [ADDR_W-1:0] col_addr;
   logic [LEN_W-1:0]  up_val;
   logic [LEN_W-1:0]  cell_val;
   logic              last_col;

   assign kept         = (cmd.data != SPACE_CODE) && (cmd.data != NEWLINE_CODE);
   assign ref_wr_addr  = ref_count_ff[ADDR_W-1:0];
   assign cand_wr_addr = cand_count_ff[ADDR_W-1:0];
   assign row_addr     = ADDR_W'(row_ff - LEN_W'(1));
   assign col_addr     = col_ff[ADDR_W-1:0];
   assign last_col     = (col_ff + LEN_W'(1)) == cand_count_ff;

   // The first row reads its upper neighbors from the column index plus one.
   assign up_val = (row_ff == LEN_W'(1)) ? (col_ff + LEN_W'(1)) : dp_rd_ff;

   edp_cell #(
      .W (LEN_W)
   ) u_cell (
      .up        (up_val),
      .left      (left_ff),
      .diag      (diag_ff),
      .ref_char  (ref_rd_ff),
      .cand_char (cand_rd_ff),
      .cost_out  (cell_val)
   );

   always_comb begin
      state_in      = state_ff;
      ref_count_in  = ref_count_ff;
      cand_count_in = cand_count_ff;
      ref_over_in   = ref_over_ff;
      cand_over_in  = cand_over_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      left_in       = left_ff;
      diag_in       = diag_ff;
      dist_in       = dist_ff;
      ref_wr        = 1'b0;
      cand_wr       = 1'b0;
      res_valid     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.accept) begin
               case (cmd.func)
                  FUNC_REF: begin
                     if (kept) begin
                        if (ref_count_ff < LEN_W'(MAX_LEN)) begin
                           ref_wr       = 1'b1;
                           ref_count_in = ref_count_ff + LEN_W'(1);
                        end else begin
                           ref_over_in = 1'b1;
                        end
                     end
                  end
                  FUNC_CAND: begin
                     if (kept) begin
                        if (cand_count_ff < LEN_W'(MAX_LEN)) begin
                           cand_wr       = 1'b1;
                           cand_count_in = cand_count_ff + LEN_W'(1);
                        end else begin
                           cand_over_in = 1'b1;
                        end
                     end
                  end
                  FUNC_FINISH: begin
                     // Empty strings and overflow need no table walk.
                     if (ref_over_ff || cand_over_ff) begin
                        dist_in  = '0;
                        state_in = ST_RESULT;
                     end else if (ref_count_ff == '0) begin
                        dist_in  = cand_count_ff;
                        state_in = ST_RESULT;
                     end else if (cand_count_ff == '0) begin
                        dist_in  = ref_count_ff;
                        state_in = ST_RESULT;
                     end else begin
                        row_in   = LEN_W'(1);
                        state_in = ST_ROW;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_ROW: begin
            diag_in  = row_ff - LEN_W'(1);
            left_in  = row_ff;
            col_in   = '0;
            state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_CELL;
         end
         ST_CELL: begin
            left_in = cell_val;
            diag_in = up_val;
            if (last_col) begin
               if (row_ff == ref_count_ff) begin
                  dist_in  = cell_val;
                  state_in = ST_RESULT;
               end else begin
                  row_in   = row_ff + LEN_W'(1);
                  state_in = ST_ROW;
               end
            end else begin
               col_in   = col_ff + LEN_W'(1);
               state_in = ST_READ;
            end
         end
         ST_RESULT: begin
            if (out_free) begin
               res_valid     = 1'b1;
               ref_count_in  = '0;
               cand_count_in = '0;
               ref_over_in   = 1'b0;
               cand_over_in  = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ref_count_ff  <= '0;
         cand_count_ff <= '0;
         ref_over_ff   <= 1'b0;
         cand_over_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ref_count_ff  <= ref_count_in;
         cand_count_ff <= cand_count_in;
         ref_over_ff   <= ref_over_in;
         cand_over_ff  <= cand_over_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff  <= row_in;
      col_ff  <= col_in;
      left_ff <= left_in;
      diag_ff <= diag_in;
      dist_ff <= dist_in;
   end

   // Reference buffer: appended in idle, one row byte fetched per row.
   always_ff @(posedge clock) begin
      if (ref_wr) begin
         ref_mem_ff[ref_wr_addr] <= cmd.data;
      end
      if (state_ff == ST_ROW) begin
         ref_rd_ff <= ref_mem_ff[row_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cand_wr) begin
         cand_mem_ff[cand_wr_addr] <= cmd.data;
      end
      if (state_ff == ST_READ) begin
         cand_rd_ff <= cand_mem_ff[col_addr];
      end
   end

   // Row memory holds the previous row; each cell overwrites its own column.
   always_ff @(posedge clock) begin
      if (state_ff == ST_CELL) begin
         dp_mem_ff[col_addr] <= cell_val;
      end
      if (state_ff == ST_READ) begin
         dp_rd_ff <= dp_mem_ff[col_addr];
      end
   end

   assign idle               = (state_ff == ST_IDLE);
   assign result.distance    = LEN_OUT_W'(dist_ff);
   assign result.ref_length  = LEN_OUT_W'(ref_count_ff);
   assign result.cand_length = LEN_OUT_W'(cand_count_ff);
   assign result.too_long    = ref_over_ff || cand_over_ff;

endmodule

`default_nettype wire

[rtl/core/edit_distance_engine_top.sv]
// Top level of the edit distance engine: stream ports, result register and checks.
//
// Usage: the request channel carries one byte per word. req_tuser selects the
// operation (append to the reference, append to the candidate, or finish) and
// req_tdata carries the byte. Space and newline bytes are dropped on entry.
// An append produces nothing. A finish word starts the
// distance computation and yields exactly one response word holding the
// Levenshtein distance, both kept lengths and a too-long flag; afterwards both
// buffers are empty again.
// For a finish with kept lengths R and C (both nonzero, no overflow), a single
// cell unit walks the R*C table entries one at a time: each entry has a step
// that reads the row memory and candidate byte and one that computes and
// writes back, and each row begins with a step that fetches the reference
// byte. Empty or too-long strings skip the table walk.
// req_tready is low while a computation runs or its result waits for room.
// The response sits in an output register; a stalled receiver holds it there
// while further append words are still taken. Reset empties both buffers and
// drops any pending response.
`default_nettype none

module edit_distance_engine_top #(
   parameter int MAX_LEN = edp_pkg::MAX_LEN_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] char_byte
   input  wire logic [1:0]  req_tuser,   // [1:0] func
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // [10:0] distance, [21:11] ref_length,
                                         // [32:22] cand_length, [39:33] zero
   output logic [0:0]       rsp_tuser    // [0] too_long
);
   import edp_pkg::*;

   req_cmd_type cmd;
   logic        core_idle;
   logic        res_valid;
   result_type  result;

   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_data_ff,  rsp_data_in;

   assign req_tready = core_idle;
   assign cmd.accept = req_tvalid && req_tready;
   assign cmd.func   = func_type'(req_tuser);
   assign cmd.data   = req_tdata;

   edp_core #(
      .MAX_LEN (MAX_LEN)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .out_free  (!rsp_valid_ff),
      .idle      (core_idle),
      .res_valid (res_valid),
      .result    (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_data_ff.cand_length, rsp_data_ff.ref_length,
                        rsp_data_ff.distance};
   assign rsp_tuser  = rsp_data_ff.too_long;

   // A finish word always takes the engine out of idle.
   a_finish_busy : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser == FUNC_FINISH)) |=> !req_tready)
      else $error("engine stayed ready after a finish word");

   // An overflowed pair must report a zero distance.
   a_too_long_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata[10:0] == 11'd0))
      else $error("too-long result carries a nonzero distance");

   // The distance never exceeds the longer of the two strings.
   a_dist_bound : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0] && (MAX_LEN < 2048)) |->
         ((rsp_tdata[10:0] <= rsp_tdata[21:11]) || (rsp_tdata[10:0] <= rsp_tdata[32:22])))
      else $error("distance exceeds both string lengths");

   // A new result is only produced into an empty output register.
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      res_valid |-> !rsp_valid_ff)
      else $error("result produced while the output register is full");

endmodule

`default_nettype wire

[bench/edit_distance_engine_top_tb.sv]
// Self-checking stream testbench for the edit distance engine with a built-in distance predictor.
`default_nettype none

module edit_distance_engine_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import edp_pkg::*;

   localparam int MAX_LEN = edp_pkg::MAX_LEN_DEF;

   // The selector value that the block must ignore.
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   // Number of counted words in the random part, and the length of the
   // deliberate response stall.
   localparam int RANDOM_WORDS = 500;
   localparam int HOLD_CYCLES  = 400;

   // Cycles to wait after the last response before the verdict, so that a stray
   // response from a finish would still show up.
   localparam int SETTLE_CYCLES = 40;

   // Ports. Every input starts from a known value.
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] char_byte
   logic [1:0]  req_tuser  = FUNC_REF; // [1:0] func
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;            // [10:0] distance, [21:11] ref_length,
                                      // [32:22] cand_length, [39:33] zero
   logic [0:0]  rsp_tuser;            // [0] too_long

   edit_distance_engine_top #(
      .MAX_LEN(MAX_LEN)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   // 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Predictor state: the kept strings and the overflow flags, exactly as
   // the block should hold them between finish words.
   // ------------------------------------------------------------------
   logic [7:0] ref_text[$];
   logic [7:0] cand_text[$];
   bit         ref_overflow  = 1'b0;
   bit         cand_overflow = 1'b0;

   // Distances we still wait for, oldest first.
   result_type expected_results[$];

   int  mismatch_count = 0;
   int  live_words     = 0;   // words that actually change the block's state
   bit  calm           = 1'b0; // when set, neither side inserts idle cycles
   bit  hold_rsp_request = 1'b0;

   // Classic single-row dynamic program over the kept strings. Unit cost
   // for insert, delete and substitute.
   function automatic logic [10:0] edit_cost();
      int row [0:MAX_LEN];
      int diag;
      int up;
      int cost;
      for (int j = 0; j <= cand_text.size(); j++) row[j] = j;
      for (int i = 1; i <= ref_text.size(); i++) begin
         diag   = row[0];
         row[0] = i;
         for (int j = 1; j <= cand_text.size(); j++) begin
            up   = row[j];
            cost = (ref_text[i-1] == cand_text[j-1]) ? 0 : 1;
            row[j] = up + 1;
            if (row[j-1] + 1 < row[j]) row[j] = row[j-1] + 1;
            if (diag + cost < row[j]) row[j] = diag + cost;
            diag = up;
         end
      end
      return 11'(row[cand_text.size()]);
   endfunction

   // Advances the predictor by one accepted word. Returns 1 when the word
   // produces a response, which is then placed in outcome.
   function automatic bit track_word(input logic [1:0] f, input logic [7:0] b,
                                     output result_type outcome);
      bit kept;
      bit produced;
      kept     = (b != SPACE_CODE) && (b != NEWLINE_CODE);
      produced = 1'b0;
      outcome  = '0;
      case (f)
         FUNC_REF: begin
            if (kept) begin
               if (ref_text.size() < MAX_LEN) ref_text.push_back(b);
               else ref_overflow = 1'b1;
            end
         end
         FUNC_CAND: begin
            if (kept) begin
               if (cand_text.size() < MAX_LEN) cand_text.push_back(b);
               else cand_overflow = 1'b1;
            end
         end
         FUNC_FINISH: begin
            // Too long wins over the distance, but the saturated lengths are
            // still reported.
            outcome.too_long    = ref_overflow | cand_overflow;
            outcome.distance    = outcome.too_long ? '0 : edit_cost();
            outcome.ref_length  = 11'(ref_text.size());
            outcome.cand_length = 11'(cand_text.size());
            ref_text.delete();
            cand_text.delete();
            ref_overflow  = 1'b0;
            cand_overflow = 1'b0;
            produced = 1'b1;
         end
         default: ; // unused selector: no effect at all
      endcase
      return produced;
   endfunction

   task automatic flag_mismatch(input string what, input result_type want,
                                input result_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("[%0t] %s: expected dist=%0d ref=%0d cand=%0d long=%0b, ",
                  $realtime, what, want.distance, want.ref_length, want.cand_length,
                  want.too_long, "got dist=%0d ref=%0d cand=%0d long=%0b",
                  got.distance, got.ref_length, got.cand_length, got.too_long);
   endtask

   // ------------------------------------------------------------------
   // Sender side. A word is offered at a rising edge and held until the
   // edge at which req_tready is seen high. Idle cycles are inserted at
   // random before a word unless the calm window is active.
   // ------------------------------------------------------------------
   task automatic send_word(input logic [1:0] f, input logic [7:0] b,
                            input bit typed = 1'b0, input result_type want = '0);
      result_type predicted;
      while (!calm && $urandom_range(99) < 16) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= f;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      // Directed rows may carry a hand-written answer; everything else
      // takes the predictor's.
      if (track_word(f, b, predicted))
         expected_results.push_back(typed ? want : predicted);
      if (f == FUNC_FINISH ||
          ((f == FUNC_REF || f == FUNC_CAND) && b != SPACE_CODE && b != NEWLINE_CODE))
         live_words++;
   endtask

   // Stop offering words until every outstanding distance has come back.
   // The task always waits on a clock edge, so req_tvalid is never lowered and raised in
   // the same step.
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_results.size() != 0);
   endtask

   // Byte source for the random part: a small alphabet so that matches are
   // common, some fully random bytes, and some bytes that must be dropped.
   function automatic logic [7:0] pick_byte();
      int r;
      r = $urandom_range(99);
      if (r < 70) return 8'h61 + 8'($urandom_range(0, 3));
      if (r < 85) return 8'($urandom_range(0, 255));
      if (r < 92) return SPACE_CODE;
      return NEWLINE_CODE;
   endfunction

   // ------------------------------------------------------------------
   // Directed table. Each row is sent copies times. Rows with typed set
   // carry an answer that can be read straight off the row sequence.
   // ------------------------------------------------------------------
   typedef struct {
      logic [1:0] func;
      logic [7:0] data;
      int         copies;
      bit         typed;
      result_type want;
   } stim_row_type;

   localparam int DIRECTED_ROWS = 19;

   stim_row_type directed_rows [0:DIRECTED_ROWS-1] = '{
      // A finish straight out of reset sees two empty strings.
      '{FUNC_FINISH, 8'h00, 1,    1'b1, '{11'd0,    11'd0,    11'd0,    1'b0}},
      // Byte extremes on both sides, swapped order: distance from predictor.
      '{FUNC_REF,    8'h00, 1,    1'b0, '0},
      '{FUNC_REF,    8'hFF, 1,    1'b0, '0},
      '{FUNC_CAND,   8'hFF, 1,    1'b0, '0},
      '{FUNC_CAND,   8'h00, 1,    1'b0, '0},
      '{FUNC_FINISH, 8'h00, 1,    1'b0, '0},
      // Space and newline are dropped, the unused selector is ignored.
      '{FUNC_REF,    8'h20, 1,    1'b0, '0},
      '{FUNC_CAND,   8'h0A, 1,    1'b0, '0},
      '{FUNC_UNUSED, 8'h41, 1,    1'b0, '0},
      '{FUNC_FINISH, 8'hFF, 1,    1'b1, '{11'd0,    11'd0,    11'd0,    1'b0}},
      // One reference byte against nothing.
      '{FUNC_REF,    8'h41, 1,    1'b0, '0},
      '{FUNC_FINISH, 8'h00, 1,    1'b1, '{11'd1,    11'd1,    11'd0,    1'b0}},
      // Identical strings.
      '{FUNC_CAND,   8'h51, 3,    1'b0, '0},
      '{FUNC_REF,    8'h51, 3,    1'b0, '0},
      '{FUNC_FINISH, 8'h00, 1,    1'b1, '{11'd0,    11'd3,    11'd3,    1'b0}},
      // Reference overflows by one byte; its length saturates.
      '{FUNC_REF,    8'h33, 1025, 1'b0, '0},
      '{FUNC_CAND,   8'h34, 3,    1'b0, '0},
      '{FUNC_FINISH, 8'h00, 1,    1'b1, '{11'd0,    11'd1024, 11'd3,    1'b1}},
      // The overflow flags must be gone after the finish.
      '{FUNC_FINISH, 8'h00, 1,    1'b1, '{11'd0,    11'd0,    11'd0,    1'b0}}
   };

   // ------------------------------------------------------------------
   // Stimulus: reset, directed table, then random sequences.
   // ------------------------------------------------------------------
   initial begin
      int kind;
      int ref_left;
      int cand_left;
      int longest;
      int seq_no;
      logic [7:0] b;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[k])
         repeat (directed_rows[k].copies)
            send_word(directed_rows[k].func, directed_rows[k].data,
                      directed_rows[k].typed, directed_rows[k].want);
      wait_for_results();

      // Random part. Most traffic is well-formed: some reference and
      // candidate bytes in random interleaving, then a finish. A few
      // sequences skip the finish so their bytes carry into the next one,
      // and a few are pure noise over all selectors.
      live_words = 0;
      seq_no     = 0;
      while (live_words < RANDOM_WORDS) begin
         seq_no++;
         calm = (live_words >= 150 && live_words < 300);

         // Hold the receiver off for a long stretch while words keep coming:
         // one result parks in the output register and the next finish
         // stalls the request channel.
         if (seq_no == 8 || seq_no == 30) hold_rsp_request = 1'b1;
         // Now and then let everything drain before going on.
         if (seq_no % 12 == 0) wait_for_results();

         kind = $urandom_range(99);
         if (kind < 8) begin
            repeat ($urandom_range(3, 10))
               send_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
         end else begin
            longest   = (kind < 12) ? 40 : 12;
            ref_left  = $urandom_range(0, longest);
            cand_left = $urandom_range(0, longest);
            while (ref_left + cand_left > 0) begin
               if ($urandom_range(99) < 3)
                  send_word(FUNC_UNUSED, 8'($urandom_range(0, 255)));
               b = pick_byte();
               if (ref_left > 0 && (cand_left == 0 || $urandom_range(1) == 1)) begin
                  send_word(FUNC_REF, b);
                  if (b != SPACE_CODE && b != NEWLINE_CODE) ref_left--;
               end else begin
                  send_word(FUNC_CAND, b);
                  if (b != SPACE_CODE && b != NEWLINE_CODE) cand_left--;
               end
            end
            if (kind >= 14) send_word(FUNC_FINISH, 8'($urandom_range(0, 255)));
         end
      end
      calm = 1'b0;

      // Close any open strings so that the last bytes get checked too.
      send_word(FUNC_FINISH, 8'h00);
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // ------------------------------------------------------------------
   // Receiver side. Ready drops at random, except in the calm window; on
   // request it is held low, and the stall is counted out here with HOLD_CYCLES.
   // ------------------------------------------------------------------
   initial begin
      forever begin
         @(posedge clock);
         if (hold_rsp_request) begin
            hold_rsp_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_tready <= calm || ($urandom_range(99) >= 16);
         end
      end
   end

   // ------------------------------------------------------------------
   // Response checker. Values are read at the edge before any update of
   // that edge lands, so the sample is the word that was on the bus.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.distance    = rsp_tdata[10:0];
         got.ref_length  = rsp_tdata[21:11];
         got.cand_length = rsp_tdata[32:22];
         got.too_long    = rsp_tuser[0];
         if (expected_results.size() == 0) begin
            flag_mismatch("unexpected response", '0, got);
         end else begin
            want = expected_results.pop_front();
            if (got.distance !== want.distance || got.ref_length !== want.ref_length ||
                got.cand_length !== want.cand_length || got.too_long !== want.too_long)
               flag_mismatch("response mismatch", want, got);
         end
      end
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin
      #20_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

`default_nettype wire
